// File: hdl/ordered_list_insert_remove_defines.svh
// ----------------------------------------------------------------------------
// Ordered list assertion macros
// Concurrent assertion shorthands shared by the ordered list modules.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_REMOVE_DEFINES_SVH
`define ORDERED_LIST_INSERT_REMOVE_DEFINES_SVH
`ifndef ASSERT_OFF
// The expression holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: hdl/olir_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list package
// Field widths, command and status codes, and controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package olir_pkg;

   localparam int CMD_W     = 2;
   localparam int POS_W     = 6;
   localparam int VAL_W     = 32;
   localparam int STAT_W    = 2;
   localparam int CNT_OUT_W = 7;

   // Stream word widths, rounded up to whole bytes.
   localparam int REQ_TDATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((VAL_W + CNT_OUT_W + 7) / 8) * 8;

   localparam logic [CMD_W-1:0] OP_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] OP_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [CMD_W-1:0] OP_READ   = 2'd3;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              capture;
      logic              move_init;
      logic              move_step;
      logic              rd_only;
      logic              wr_word;
      logic              count_inc;
      logic              count_dec;
      logic              rsp_load;
      logic [STAT_W-1:0] rsp_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CMD_W-1:0] op;
      logic             full;
      logic             pos_gt;
      logic             pos_ge;
      logic             no_move;
      logic             last_rd;
      logic             rsp_busy;
   } stat_type;

endpackage

`default_nettype wire

// File: hdl/olir_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered list controller
// Sequences one command word: checks, shift loop, count update and response.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ordered_list_insert_remove_defines.svh"

module olir_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  wire olir_pkg::stat_type stat,
   output olir_pkg::cmd_type   cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_MOVE   = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0]                  state_ff, state_in;
   logic [olir_pkg::STAT_W-1:0] code_ff, code_in;
   logic                        op_shifts;

   // Only insert and remove run the shift loop.
   assign op_shifts = (stat.op == olir_pkg::OP_INSERT) || (stat.op == olir_pkg::OP_REMOVE);

   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      cmd            = '0;
      cmd.rsp_status = code_ff;
      req_tready     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_RESP;
            code_in  = olir_pkg::ST_DONE;
            unique case (stat.op)
               olir_pkg::OP_APPEND: begin
                  if (stat.full) begin
                     code_in = olir_pkg::ST_FULL;
                  end else begin
                     cmd.wr_word   = 1'b1;
                     cmd.count_inc = 1'b1;
                  end
               end
               olir_pkg::OP_INSERT: begin
                  if (stat.full) begin
                     code_in = olir_pkg::ST_FULL;
                  end else if (stat.pos_gt) begin
                     code_in = olir_pkg::ST_RANGE;
                  end else if (stat.no_move) begin
                     cmd.wr_word   = 1'b1;
                     cmd.count_inc = 1'b1;
                  end else begin
                     cmd.move_init = 1'b1;
                     state_in      = S_MOVE;
                  end
               end
               olir_pkg::OP_REMOVE: begin
                  if (stat.pos_ge) begin
                     code_in = olir_pkg::ST_RANGE;
                  end else if (stat.no_move) begin
                     cmd.count_dec = 1'b1;
                  end else begin
                     cmd.move_init = 1'b1;
                     state_in      = S_MOVE;
                  end
               end
               olir_pkg::OP_READ: begin
                  if (stat.pos_ge) begin
                     code_in = olir_pkg::ST_RANGE;
                  end else begin
                     cmd.rd_only = 1'b1;
                  end
               end
            endcase
         end
         S_MOVE: begin
            cmd.move_step = 1'b1;
            if (stat.last_rd) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // The last moved word is written this cycle.
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (stat.op == olir_pkg::OP_INSERT) begin
               cmd.wr_word   = 1'b1;
               cmd.count_inc = 1'b1;
            end else begin
               cmd.count_dec = 1'b1;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   `ASSERT_IMPLIES(a_load_free, clock, reset, cmd.rsp_load, !stat.rsp_busy, "response overwritten")
   `ASSERT_IMPLIES(a_move_op, clock, reset, cmd.move_step, op_shifts, "shift for a non-shift command")

endmodule

`default_nettype wire

// File: hdl/olir_dpath.sv
// ----------------------------------------------------------------------------
// Ordered list datapath
// Entry memory, count, shift address counters and the response register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ordered_list_insert_remove_defines.svh"

module olir_dpath #(
   parameter int DEPTH     = 64,
   parameter int WORD_BITS = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire olir_pkg::cmd_type              cmd,
   output olir_pkg::stat_type                  stat,
   input  wire  [olir_pkg::CMD_W-1:0]          req_cmd,
   input  wire  [olir_pkg::POS_W-1:0]          req_position,
   input  wire  [olir_pkg::VAL_W-1:0]          req_item_value,
   input  wire                                 rsp_tready,
   output logic                                rsp_tvalid,
   output logic [olir_pkg::STAT_W-1:0]         rsp_status,
   output logic [olir_pkg::VAL_W-1:0]          rsp_read_value,
   output logic [olir_pkg::CNT_OUT_W-1:0]      rsp_entry_count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > olir_pkg::POS_W + 1) ? CW : olir_pkg::POS_W + 1;

   logic [WORD_BITS-1:0] slots_ff [DEPTH];
   logic [WORD_BITS-1:0] rdata_ff;

   logic [olir_pkg::CMD_W-1:0]     op_ff;
   logic [olir_pkg::POS_W-1:0]     pos_ff;
   logic [WORD_BITS-1:0]           word_ff;
   logic [CW-1:0]                  count_ff, count_in;
   logic [AW-1:0]                  rd_addr_ff, rd_addr_in;
   logic [AW-1:0]                  wr_addr_ff, wr_addr_in;
   logic                           move_wr_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [olir_pkg::STAT_W-1:0]    rsp_status_ff;
   logic [olir_pkg::VAL_W-1:0]     rsp_value_ff;
   logic [olir_pkg::CNT_OUT_W-1:0] rsp_count_ff;

   logic [XW-1:0] pos_x, cnt_x, rd_x, ins_start_x, rem_start_x;
   logic          is_insert;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_wa, mem_ra, word_addr;
   logic [WORD_BITS-1:0] mem_wd;

   assign pos_x       = XW'(pos_ff);
   assign cnt_x       = XW'(count_ff);
   assign rd_x        = XW'(rd_addr_ff);
   assign ins_start_x = cnt_x - XW'(1);
   assign rem_start_x = pos_x + XW'(1);
   assign is_insert   = (op_ff == olir_pkg::OP_INSERT);

   assign stat.op       = op_ff;
   assign stat.full     = (cnt_x == XW'(DEPTH));
   assign stat.pos_gt   = (pos_x > cnt_x);
   assign stat.pos_ge   = (pos_x >= cnt_x);
   assign stat.no_move  = is_insert ? (pos_x == cnt_x) : (rem_start_x == cnt_x);
   assign stat.last_rd  = is_insert ? (rd_x == pos_x) : (rd_x == ins_start_x);
   assign stat.rsp_busy = rsp_valid_ff && !rsp_tready;

   // An append lands after the last entry, an insert at its position.
   assign word_addr = (op_ff == olir_pkg::OP_APPEND) ? cnt_x[AW-1:0] : pos_x[AW-1:0];

   // The moved word from the previous read has priority on the write port;
   // the controller never asks for a word write in that cycle.
   assign mem_we = move_wr_ff || cmd.wr_word;
   assign mem_wa = move_wr_ff ? wr_addr_ff : word_addr;
   assign mem_wd = move_wr_ff ? rdata_ff : word_ff;
   assign mem_re = cmd.move_step || cmd.rd_only;
   assign mem_ra = cmd.rd_only ? pos_x[AW-1:0] : rd_addr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slots_ff[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rdata_ff <= slots_ff[mem_ra];
      end
   end

   always_comb begin
      rd_addr_in = rd_addr_ff;
      wr_addr_in = wr_addr_ff;
      if (cmd.move_init) begin
         rd_addr_in = is_insert ? ins_start_x[AW-1:0] : rem_start_x[AW-1:0];
      end else if (cmd.move_step) begin
         if (is_insert) begin
            rd_addr_in = rd_addr_ff - AW'(1);
            wr_addr_in = rd_addr_ff + AW'(1);
         end else begin
            rd_addr_in = rd_addr_ff + AW'(1);
            wr_addr_in = rd_addr_ff - AW'(1);
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         move_wr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         move_wr_ff   <= cmd.move_step;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      wr_addr_ff <= wr_addr_in;
      if (cmd.capture) begin
         op_ff   <= req_cmd;
         pos_ff  <= req_position;
         word_ff <= WORD_BITS'(req_item_value);
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_count_ff  <= olir_pkg::CNT_OUT_W'(count_ff);
         if ((op_ff == olir_pkg::OP_READ) && (cmd.rsp_status == olir_pkg::ST_DONE)) begin
            rsp_value_ff <= olir_pkg::VAL_W'(rdata_ff);
         end else begin
            rsp_value_ff <= '0;
         end
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

   `ASSERT_HOLDS(a_count_bound, clock, reset, cnt_x <= XW'(DEPTH), "entry count above depth")
   `ASSERT_HOLDS(a_one_write, clock, reset, !(move_wr_ff && cmd.wr_word), "two writes in one cycle")

endmodule

`default_nettype wire

// File: hdl/ordered_list_insert_remove.sv
// ----------------------------------------------------------------------------
// Ordered list with insert and remove by position
// Bounded list of words in a memory with one read and one write port, one
// command at a time.
// ----------------------------------------------------------------------------
// Usage: each req word carries a command in req_tuser (append, insert before
// a position, remove at a position, read at a position) and a position and
// data word in req_tdata. Every command returns exactly one rsp word with a
// status in rsp_tuser (done, full, position out of range) and the read word
// and the entry count after the command in rsp_tdata.
// Sequence: append, read, any refused command, an insert at the end and a
// remove of the last entry pass a check state and a load state before
// rsp_tvalid rises. An insert or remove that moves n later entries (1 to
// DEPTH - 1) through the entry memory, one read and one write per cycle,
// passes the check, n moves, a drain state that writes the last moved word,
// a finish state that stores the new word or drops the count, and the load.
// req_tready rises together with rsp_tvalid, so no new command is taken
// before the last response is loaded; the shift loop sets the command rate.
// Reset empties the list at once; entries need no clearing.
// A stalled receiver holds the response in the output register; the block
// still accepts the next command and processes it, then waits with its
// response until the previous one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_insert_remove #(
   parameter int DEPTH     = 64,
   parameter int WORD_BITS = 32
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // Request channel.
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // [5:0] position, [37:6] item_value, [39:38] zero
   input  wire  [olir_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // [1:0] cmd
   input  wire  [olir_pkg::CMD_W-1:0]            req_tuser,
   // Response channel.
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // [31:0] read_value, [38:32] entry_count, [39] zero
   output logic [olir_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // [1:0] status
   output logic [olir_pkg::STAT_W-1:0]           rsp_tuser
);

   olir_pkg::cmd_type  cmd;
   olir_pkg::stat_type stat;

   logic [olir_pkg::POS_W-1:0]     req_position;
   logic [olir_pkg::VAL_W-1:0]     req_item_value;
   logic [olir_pkg::VAL_W-1:0]     rsp_read_value;
   logic [olir_pkg::CNT_OUT_W-1:0] rsp_entry_count;

   // Unpack the request word; bits above the fields are padding.
   assign req_position   = req_tdata[olir_pkg::POS_W-1:0];
   assign req_item_value = req_tdata[olir_pkg::POS_W +: olir_pkg::VAL_W];

   // Pack the response word, zero filled up to the byte boundary.
   assign rsp_tdata = olir_pkg::RSP_TDATA_W'({rsp_entry_count, rsp_read_value});

   // The controller owns the sequence of one command.
   olir_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath holds the entries, the count and the response register.
   olir_dpath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_cmd         (req_tuser),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_status      (rsp_tuser),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

`default_nettype wire
